FILE: rtl/ptle_pkg.sv
// Shared constants, codes and control structs for the paged translation block.
`timescale 1ns / 1ps
package ptle_pkg;

  localparam int MAX_PROCESSES     = 8;
  localparam int PAGES_PER_PROCESS = 16;
  localparam int PAGE_SIZE         = 64;
  localparam int MAX_FRAMES        = 16;
  localparam int NUM_ENTRIES       = MAX_PROCESSES * PAGES_PER_PROCESS;

  localparam int PID_W   = $clog2(MAX_PROCESSES);
  localparam int PAGE_W  = $clog2(PAGES_PER_PROCESS);
  localparam int OFF_W   = $clog2(PAGE_SIZE);
  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int IDX_W   = $clog2(NUM_ENTRIES);
  localparam int VA_W    = 10;
  localparam int PA_W    = 10;
  localparam int STAMP_W = 5;
  localparam int NP_W    = 4;
  localparam int NF_W    = 5;
  localparam int FU_W    = 5;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCESSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES    = 1'd1;

  localparam logic [NP_W-1:0]    NP_RESET  = NP_W'(MAX_PROCESSES);
  localparam logic [NF_W-1:0]    NF_RESET  = NF_W'(MAX_FRAMES);
  localparam logic [STAMP_W-1:0] TIME_WRAP = 5'd31;

  typedef struct packed {
    logic accept;
    logic check;
    logic scan_rd;
    logic commit;
    logic clear_wr;
    logic load_out;
  } ptle_cmd_t;

  typedef struct packed {
    logic ignore;
    logic hit;
    logic alloc;
    logic wrap;
    logic cnt_last;
    logic out_busy;
  } ptle_sts_t;

endpackage

FILE: rtl/ptle_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ptle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ptle_ctrl.sv
// Controller state machine for the paged translation block.
`timescale 1ns / 1ps
module ptle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptle_pkg::ptle_sts_t sts,
  output ptle_pkg::ptle_cmd_t cmd
);
  import ptle_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CHECK     = 7'b0000010,
    ST_SCAN      = 7'b0000100,
    ST_SCAN_LAST = 7'b0001000,
    ST_COMMIT    = 7'b0010000,
    ST_CLEAR     = 7'b0100000,
    ST_OUT       = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (sts.ignore) state_next = ST_OUT;
        else if (sts.hit || sts.alloc) state_next = ST_COMMIT;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) state_next = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sts.wrap ? ST_CLEAR : ST_OUT;
      end
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/ptle_dpath.sv
// Datapath: config, page entries, LRU scan, timestamp clear and result registers.
`timescale 1ns / 1ps
module ptle_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ptle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptle_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ptle_pkg::PID_W-1:0]          process_id,
  input  logic [ptle_pkg::VA_W-1:0]           virtual_address,
  input  logic                                advance_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ptle_pkg::PA_W-1:0]           physical_address,
  output logic                                page_fault,
  output logic                                evicted,
  output logic [ptle_pkg::PID_W-1:0]          evicted_process,
  output logic [ptle_pkg::PAGE_W-1:0]         evicted_page,
  output logic [ptle_pkg::FRAME_W-1:0]        frame_number,
  input  ptle_pkg::ptle_cmd_t                 cmd,
  output ptle_pkg::ptle_sts_t                 sts
);
  import ptle_pkg::*;

  // config
  logic [NP_W-1:0] num_processes;
  logic [NF_W-1:0] num_frames;
  logic [PID_W-1:0] np_m1;
  logic [NF_W-1:0] nf_clamp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_processes <= NP_RESET;
      num_frames    <= NF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_PROCESSES: num_processes <= cfg_data[NP_W-1:0];
        REG_NUM_FRAMES:    num_frames    <= cfg_data[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_processes == '0) np_m1 = '0;
    else if (num_processes > NP_W'(MAX_PROCESSES)) np_m1 = PID_W'(MAX_PROCESSES - 1);
    else np_m1 = PID_W'(num_processes - NP_W'(1));
    if (num_frames == '0) nf_clamp = NF_W'(1);
    else if (num_frames > NF_W'(MAX_FRAMES)) nf_clamp = NF_W'(MAX_FRAMES);
    else nf_clamp = num_frames;
  end

  // access registers
  logic [PID_W-1:0] pid;
  logic [VA_W-1:0]  va;
  logic             adv;
  logic [IDX_W-1:0] cur;
  logic [OFF_W-1:0] offset;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid <= process_id;
      va  <= virtual_address;
      adv <= advance_time;
    end
  end

  assign cur    = {pid, va[OFF_W+PAGE_W-1:OFF_W]};
  assign offset = va[OFF_W-1:0];

  // entry state
  logic [NUM_ENTRIES-1:0] present;
  logic [FU_W-1:0]        frames_used;
  logic [STAMP_W-1:0]     time_counter;
  logic [IDX_W-1:0]       cnt;
  logic [IDX_W-1:0]       last_idx;

  assign last_idx = {np_m1, {PAGE_W{1'b1}}};

  logic [FRAME_W-1:0] frame_rdata;
  logic [STAMP_W-1:0] stamp_rdata;
  logic               frame_we;
  logic [FRAME_W-1:0] frame_sel;
  logic               stamp_we;
  logic [IDX_W-1:0]   stamp_waddr;
  logic [STAMP_W-1:0] stamp_wdata;

  ptle_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_ENTRIES)) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (cur),
    .wdata (frame_sel),
    .re    (cmd.check || cmd.scan_rd),
    .raddr (cmd.check ? cur : cnt),
    .rdata (frame_rdata)
  );

  ptle_ram #(.WIDTH(STAMP_W), .DEPTH(NUM_ENTRIES)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .re    (cmd.scan_rd),
    .raddr (cnt),
    .rdata (stamp_rdata)
  );

  // path flags latched at check
  logic hit_q, alloc_q;
  // LRU search
  logic               cmp_vld;
  logic [IDX_W-1:0]   cmp_idx;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic [FRAME_W-1:0] best_frame;
  logic               evict;
  logic               mapped;

  assign evict  = !hit_q && !alloc_q && found;
  assign mapped = hit_q || alloc_q || found;

  always_comb begin
    if (hit_q) frame_sel = frame_rdata;
    else if (alloc_q) frame_sel = frames_used[FRAME_W-1:0];
    else frame_sel = best_frame;
  end

  assign frame_we = cmd.commit && mapped;
  assign stamp_we = cmd.commit || cmd.clear_wr;
  assign stamp_waddr = cmd.clear_wr ? cnt : cur;
  always_comb begin
    if (cmd.clear_wr) stamp_wdata = (cnt == cur) ? STAMP_W'(1) : '0;
    else stamp_wdata = time_counter;
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      hit_q   <= present[cur];
      alloc_q <= !present[cur] && (frames_used < nf_clamp);
    end
    if (cmp_vld && present[cmp_idx] && (!found || stamp_rdata < best_stamp)) begin
      best_idx   <= cmp_idx;
      best_stamp <= stamp_rdata;
      best_frame <= frame_rdata;
    end
    cmp_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present      <= '0;
      frames_used  <= '0;
      time_counter <= '0;
      cnt          <= '0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
      if (cmd.check) begin
        found <= 1'b0;
      end else if (cmp_vld && present[cmp_idx]) begin
        found <= 1'b1;
      end
      if (cmd.check || cmd.commit) begin
        cnt <= '0;
      end else if (cmd.scan_rd || cmd.clear_wr) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (cmd.commit) begin
        if (evict) present[best_idx] <= 1'b0;
        if (mapped) present[cur] <= 1'b1;
        if (alloc_q) frames_used <= frames_used + FU_W'(1);
        time_counter <= ((time_counter == TIME_WRAP) ? STAMP_W'(1) : time_counter)
                        + STAMP_W'(adv);
      end
    end
  end

  // result staging
  logic [PA_W-1:0]    res_phys;
  logic               res_fault;
  logic               res_evict;
  logic [IDX_W-1:0]   res_ev_idx;
  logic [FRAME_W-1:0] res_frame;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_phys   <= '0;
      res_fault  <= 1'b0;
      res_evict  <= 1'b0;
      res_ev_idx <= '0;
      res_frame  <= '0;
    end else if (cmd.commit) begin
      res_phys   <= mapped ? PA_W'({frame_sel, offset}) : '0;
      res_fault  <= !hit_q;
      res_evict  <= evict;
      res_ev_idx <= evict ? best_idx : '0;
      res_frame  <= mapped ? frame_sel : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      physical_address <= res_phys;
      page_fault       <= res_fault;
      evicted          <= res_evict;
      evicted_process  <= res_ev_idx[IDX_W-1:PAGE_W];
      evicted_page     <= res_ev_idx[PAGE_W-1:0];
      frame_number     <= res_frame;
    end
  end

  always_comb begin
    sts.ignore   = pid > np_m1;
    sts.hit      = present[cur];
    sts.alloc    = frames_used < nf_clamp;
    sts.wrap     = time_counter == TIME_WRAP;
    sts.cnt_last = cnt == last_idx;
    sts.out_busy = out_valid && out_stall;
  end

endmodule

FILE: rtl/paged_translation_lru_evict_core.sv
// Top level: paged address translation with LRU eviction.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | process_id, virtual_address, advance_time
//  out     | output    | out_valid / out_stall  | physical_address, page_fault, evicted,
//          |           |                        | evicted_process, evicted_page, frame_number
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One access at a time. A hit or free-frame miss goes through check, commit and output; an
// ignored process id goes from check straight to output. A miss with no free frame adds a
// scan of num_processes*16 entries, one per cycle through the entry RAMs, before commit; a
// timestamp wrap adds a clear pass over the same entries after commit.
// Reset (synchronous) clears the present bits at once.
// A stalled result waits in the output register; the next access is taken meanwhile.
`timescale 1ns / 1ps
module paged_translation_lru_evict_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ptle_pkg::PID_W-1:0]      process_id,
  input  logic [ptle_pkg::VA_W-1:0]       virtual_address,
  input  logic                            advance_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ptle_pkg::PA_W-1:0]       physical_address,
  output logic                            page_fault,
  output logic                            evicted,
  output logic [ptle_pkg::PID_W-1:0]      evicted_process,
  output logic [ptle_pkg::PAGE_W-1:0]     evicted_page,
  output logic [ptle_pkg::FRAME_W-1:0]    frame_number,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptle_pkg::*;

  ptle_cmd_t cmd;
  ptle_sts_t sts;

  ptle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptle_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .process_id       (process_id),
    .virtual_address  (virtual_address),
    .advance_time     (advance_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .physical_address (physical_address),
    .page_fault       (page_fault),
    .evicted          (evicted),
    .evicted_process  (evicted_process),
    .evicted_page     (evicted_page),
    .frame_number     (frame_number),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
